// ===== rtl/core/motor_lock_controller_core_macros.svh =====
// Assertion macros for the motor lock controller core.
// Used by modules that hold concurrent checks; expects clk and rst in scope.
`ifndef MOTOR_LOCK_CONTROLLER_CORE_MACROS_SVH
`define MOTOR_LOCK_CONTROLLER_CORE_MACROS_SVH

// Condition holds at every edge outside reset.
`define MLC_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition on the same edge.
`define MLC_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Condition on the following edge.
`define MLC_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mlc_pkg.sv =====
// Shared types and codes for the motor lock controller core.
// No dependencies; imported by the interfaces and modules of the block.
package mlc_pkg;

  localparam int TIMER_WIDTH      = 16;
  localparam int FAIL_COUNT_WIDTH = 12;
  localparam int CFG_DATA_WIDTH   = 32;
  localparam int CFG_ADDR_WIDTH   = 5;

  localparam logic [1:0] POS_LOCKED   = 2'd0;
  localparam logic [1:0] POS_UNLOCKED = 2'd1;
  localparam logic [1:0] POS_BETWEEN  = 2'd2;
  localparam logic [1:0] POS_CONFLICT = 2'd3;

  localparam logic [1:0] ACT_IDLE   = 2'd0;
  localparam logic [1:0] ACT_UNLOCK = 2'd1;
  localparam logic [1:0] ACT_LOCK   = 2'd2;

  localparam logic [1:0] KIND_OFF     = 2'd0;
  localparam logic [1:0] KIND_PROTECT = 2'd1;
  localparam logic [1:0] KIND_SETTLE  = 2'd2;

  localparam logic [1:0] REQ_LOCK   = 2'd1;
  localparam logic [1:0] REQ_UNLOCK = 2'd2;

  localparam logic [2:0] REG_PROTECT   = 3'd0;
  localparam logic [2:0] REG_SETTLE    = 3'd1;
  localparam logic [2:0] REG_SLEEP     = 3'd2;
  localparam logic [2:0] REG_AUTO_LOCK = 3'd3;
  localparam logic [2:0] REG_FAIL_THR  = 3'd4;

  typedef struct packed {
    logic [TIMER_WIDTH-1:0]      protect_ticks;
    logic [TIMER_WIDTH-1:0]      settle_ticks;
    logic [TIMER_WIDTH-1:0]      sleep_ticks;
    logic [TIMER_WIDTH-1:0]      auto_lock_ticks;
    logic [FAIL_COUNT_WIDTH-1:0] fail_threshold;
  } mlc_cfg_t;

  typedef struct packed {
    logic [1:0] request;
    logic       unlock_switch;
    logic       lock_switch;
  } mlc_tick_t;

  typedef struct packed {
    logic                        bridge_in1;
    logic                        bridge_in2;
    logic                        driver_awake;
    logic                        motor_power;
    logic [1:0]                  position;
    logic [1:0]                  action;
    logic [FAIL_COUNT_WIDTH-1:0] lock_fails;
    logic [FAIL_COUNT_WIDTH-1:0] unlock_fails;
    logic                        blocked;
    logic                        timed_out;
  } mlc_result_t;

  typedef struct packed {
    logic [1:0]                  run_action;
    logic [TIMER_WIDTH-1:0]      motor_left;
    logic [1:0]                  motor_kind;
    logic [TIMER_WIDTH-1:0]      sleep_left;
    logic                        sleep_on;
    logic [FAIL_COUNT_WIDTH-1:0] lock_fails;
    logic [FAIL_COUNT_WIDTH-1:0] unlock_fails;
    logic [1:0]                  prev_switches;
    logic                        in1;
    logic                        in2;
    logic                        awake;
    logic                        power;
    logic                        started;
  } mlc_state_t;

endpackage

// ===== rtl/core/mlc_tick_if.sv =====
// Input channel of the motor lock controller: one tick per transfer.
// Depends on mlc_pkg.
interface mlc_tick_if;
  import mlc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] request;
  logic       unlock_switch;
  logic       lock_switch;

  modport source (output valid, output request, output unlock_switch, output lock_switch,
                  input ready);
  modport sink   (input valid, input request, input unlock_switch, input lock_switch,
                  output ready);
endinterface

// ===== rtl/core/mlc_status_if.sv =====
// Result channel of the motor lock controller: one status item per transfer.
// Depends on mlc_pkg.
interface mlc_status_if;
  import mlc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        bridge_in1;
  logic                        bridge_in2;
  logic                        driver_awake;
  logic                        motor_power;
  logic [1:0]                  position;
  logic [1:0]                  action;
  logic [FAIL_COUNT_WIDTH-1:0] lock_fails;
  logic [FAIL_COUNT_WIDTH-1:0] unlock_fails;
  logic                        blocked;
  logic                        timed_out;

  modport source (output valid, output bridge_in1, output bridge_in2, output driver_awake,
                  output motor_power, output position, output action, output lock_fails,
                  output unlock_fails, output blocked, output timed_out, input ready);
  modport sink   (input valid, input bridge_in1, input bridge_in2, input driver_awake,
                  input motor_power, input position, input action, input lock_fails,
                  input unlock_fails, input blocked, input timed_out, output ready);
endinterface

// ===== rtl/core/mlc_cfg_regs.sv =====
// APB-style configuration registers of the motor lock controller.
// Depends on mlc_pkg.
module mlc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mlc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [mlc_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic [mlc_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                               pready,
  output mlc_pkg::mlc_cfg_t                  cfg
);
  import mlc_pkg::*;

  logic [2:0] reg_index;
  logic       write_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[CFG_ADDR_WIDTH-1:2];
  assign write_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protect_ticks   <= TIMER_WIDTH'(1000);
      cfg.settle_ticks    <= '0;
      cfg.sleep_ticks     <= TIMER_WIDTH'(200);
      cfg.auto_lock_ticks <= TIMER_WIDTH'(2000);
      cfg.fail_threshold  <= FAIL_COUNT_WIDTH'(10);
    end else if (write_en) begin
      case (reg_index)
        REG_PROTECT:   cfg.protect_ticks   <= pwdata[TIMER_WIDTH-1:0];
        REG_SETTLE:    cfg.settle_ticks    <= pwdata[TIMER_WIDTH-1:0];
        REG_SLEEP:     cfg.sleep_ticks     <= pwdata[TIMER_WIDTH-1:0];
        REG_AUTO_LOCK: cfg.auto_lock_ticks <= pwdata[TIMER_WIDTH-1:0];
        REG_FAIL_THR:  cfg.fail_threshold  <= pwdata[FAIL_COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PROTECT:   prdata = CFG_DATA_WIDTH'(cfg.protect_ticks);
      REG_SETTLE:    prdata = CFG_DATA_WIDTH'(cfg.settle_ticks);
      REG_SLEEP:     prdata = CFG_DATA_WIDTH'(cfg.sleep_ticks);
      REG_AUTO_LOCK: prdata = CFG_DATA_WIDTH'(cfg.auto_lock_ticks);
      REG_FAIL_THR:  prdata = CFG_DATA_WIDTH'(cfg.fail_threshold);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/mlc_step.sv =====
// Controller state and the single-pass tick update of the motor lock controller.
// Depends on mlc_pkg and motor_lock_controller_core_macros.svh.
module mlc_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  mlc_pkg::mlc_tick_t  tick,
  input  mlc_pkg::mlc_cfg_t   cfg,
  output mlc_pkg::mlc_result_t result
);
  import mlc_pkg::*;
  `include "motor_lock_controller_core_macros.svh"

  typedef struct packed {
    mlc_state_t st;
    logic       motor_fresh;
    logic       sleep_fresh;
    logic       hit_timeout;
  } work_t;

  mlc_state_t state;
  work_t      w;
  logic [1:0] pos;
  logic [1:0] sw;

  function automatic logic [TIMER_WIDTH-1:0] at_least_one(input logic [TIMER_WIDTH-1:0] v);
    return (v == '0) ? TIMER_WIDTH'(1) : v;
  endfunction

  function automatic work_t stop_motor(input work_t c, input logic [1:0] p,
                                       input mlc_cfg_t k);
    work_t r;
    r = c;
    r.st.in1        = 1'b1;
    r.st.in2        = 1'b1;
    r.st.sleep_left = at_least_one((p == POS_LOCKED) ? k.sleep_ticks : k.auto_lock_ticks);
    r.st.sleep_on   = 1'b1;
    r.sleep_fresh   = 1'b1;
    r.st.run_action = ACT_IDLE;
    return r;
  endfunction

  function automatic work_t try_run(input work_t c, input logic want_lock,
                                    input logic [1:0] p, input mlc_cfg_t k);
    work_t r;
    logic  refuse;
    r = c;
    refuse = (want_lock ? (p == POS_LOCKED) : (p == POS_UNLOCKED)) ||
             (c.st.run_action != ACT_IDLE) ||
             (c.st.lock_fails > k.fail_threshold) ||
             (c.st.unlock_fails > k.fail_threshold);
    if (!refuse) begin
      r.st.motor_kind = KIND_PROTECT;
      r.st.motor_left = at_least_one(k.protect_ticks);
      r.motor_fresh   = 1'b1;
      r.st.sleep_on   = 1'b0;
      r.st.sleep_left = '0;
      r.st.run_action = want_lock ? ACT_LOCK : ACT_UNLOCK;
      r.st.power      = 1'b1;
      r.st.awake      = 1'b1;
      r.st.in1        = !want_lock;
      r.st.in2        = want_lock;
    end
    return r;
  endfunction

  function automatic work_t evaluate(input work_t c, input logic [1:0] p,
                                     input mlc_cfg_t k);
    work_t      r;
    logic [1:0] act;
    logic       failed;
    r = c;
    act = c.st.run_action;
    if (p != POS_BETWEEN) begin
      r.st.motor_kind = KIND_OFF;
      r.st.motor_left = '0;
      r = stop_motor(r, p, k);
      failed = ((act == ACT_LOCK) && (p != POS_LOCKED)) ||
               ((act == ACT_UNLOCK) && (p != POS_UNLOCKED));
      if (!failed) begin
        r.st.lock_fails   = '0;
        r.st.unlock_fails = '0;
      end
    end
    return r;
  endfunction

  function automatic work_t protect_timeout(input work_t c, input logic [1:0] p,
                                            input mlc_cfg_t k);
    work_t r;
    r = c;
    r.st.motor_kind = KIND_OFF;
    r.st.motor_left = '0;
    if (c.st.run_action == ACT_LOCK) begin
      r.st.lock_fails = FAIL_COUNT_WIDTH'(c.st.lock_fails + 1'b1);
    end else if (c.st.run_action == ACT_UNLOCK) begin
      r.st.unlock_fails = FAIL_COUNT_WIDTH'(c.st.unlock_fails + 1'b1);
    end
    r.hit_timeout = 1'b1;
    r = stop_motor(r, p, k);
    return r;
  endfunction

  always_comb begin
    sw = {tick.unlock_switch, tick.lock_switch};
    case (sw)
      2'b11:   pos = POS_CONFLICT;
      2'b10:   pos = POS_UNLOCKED;
      2'b01:   pos = POS_LOCKED;
      default: pos = POS_BETWEEN;
    endcase

    w.st          = state;
    w.motor_fresh = 1'b0;
    w.sleep_fresh = 1'b0;
    w.hit_timeout = 1'b0;

    if (!w.st.started) begin
      w.st.started       = 1'b1;
      w.st.prev_switches = sw;
      if (pos != POS_LOCKED) begin
        w = try_run(w, 1'b1, pos, cfg);
      end
    end

    if (sw != w.st.prev_switches) begin
      w.st.prev_switches = sw;
      if (w.st.run_action != ACT_IDLE) begin
        if (cfg.settle_ticks == '0) begin
          w = evaluate(w, pos, cfg);
        end else begin
          w.st.motor_kind = KIND_SETTLE;
          w.st.motor_left = cfg.settle_ticks;
          w.motor_fresh   = 1'b1;
        end
      end
    end

    if ((w.st.motor_kind != KIND_OFF) && !w.motor_fresh) begin
      w.st.motor_left = TIMER_WIDTH'(w.st.motor_left - 1'b1);
      if (w.st.motor_left == '0) begin
        if (w.st.motor_kind == KIND_PROTECT) begin
          w = protect_timeout(w, pos, cfg);
        end else begin
          w.st.motor_kind = KIND_OFF;
          w = evaluate(w, pos, cfg);
        end
      end
    end

    if (w.st.sleep_on && !w.sleep_fresh) begin
      w.st.sleep_left = TIMER_WIDTH'(w.st.sleep_left - 1'b1);
      if (w.st.sleep_left == '0) begin
        w.st.sleep_on = 1'b0;
        if (w.st.run_action == ACT_IDLE) begin
          if (pos == POS_LOCKED) begin
            w.st.awake = 1'b0;
            w.st.power = 1'b0;
          end else begin
            w = try_run(w, 1'b1, pos, cfg);
          end
        end else begin
          w.st.sleep_left = at_least_one(cfg.sleep_ticks);
          w.st.sleep_on   = 1'b1;
        end
      end
    end

    if (tick.request == REQ_LOCK) begin
      w = try_run(w, 1'b1, pos, cfg);
    end else if (tick.request == REQ_UNLOCK) begin
      w = try_run(w, 1'b0, pos, cfg);
    end

    result.bridge_in1   = w.st.in1;
    result.bridge_in2   = w.st.in2;
    result.driver_awake = w.st.awake;
    result.motor_power  = w.st.power;
    result.position     = pos;
    result.action       = w.st.run_action;
    result.lock_fails   = w.st.lock_fails;
    result.unlock_fails = w.st.unlock_fails;
    result.blocked      = (w.st.lock_fails > cfg.fail_threshold) ||
                          (w.st.unlock_fails > cfg.fail_threshold);
    result.timed_out    = w.hit_timeout;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.run_action    <= ACT_IDLE;
      state.motor_left    <= '0;
      state.motor_kind    <= KIND_OFF;
      state.sleep_left    <= '0;
      state.sleep_on      <= 1'b0;
      state.lock_fails    <= '0;
      state.unlock_fails  <= '0;
      state.prev_switches <= '0;
      state.in1           <= 1'b1;
      state.in2           <= 1'b1;
      state.awake         <= 1'b0;
      state.power         <= 1'b0;
      state.started       <= 1'b0;
    end else if (advance) begin
      state <= w.st;
    end
  end

  `MLC_IMPLY(a_run_powered, state.run_action != ACT_IDLE, state.power && state.awake, "motor runs unpowered")
  `MLC_ALWAYS(a_brake_when_idle, (state.run_action == ACT_IDLE) == (state.in1 && state.in2), "bridge lines disagree with action")
  `MLC_IMPLY(a_timer_needs_run, state.motor_kind != KIND_OFF, (state.run_action != ACT_IDLE) && (state.motor_left != '0), "motor timer armed without a run")
  `MLC_ALWAYS(a_no_sleep_while_run, !(state.sleep_on && (state.run_action != ACT_IDLE)), "sleep timer armed while running")
  `MLC_NEXT(a_started_after_tick, advance, state.started, "first tick not latched")

endmodule

// ===== rtl/core/motor_lock_controller_core.sv =====
// Top level of the motor lock controller: tick input stage, step core, status register.
// Depends on mlc_pkg, mlc_tick_if, mlc_status_if, mlc_cfg_regs and mlc_step.
//
//   channel   dir  transfer when          payload
//   tick      in   tick.valid & ready     request, unlock_switch, lock_switch
//   status    out  status.valid & ready   bridge lines, position, action, fail counts
//   apb cfg   in   psel & penable & pwrite  registers 0..4 at 4*i
//
// One tick per cycle sustained while status.ready holds.
// The tick register feeds the single-pass state update, which loads the status register.
// A stalled status register holds the tick register; tick.ready drops only then.
// Reset is synchronous and clears state and valid flags; config registers take defaults.
module motor_lock_controller_core (
  input  logic                               clk,
  input  logic                               rst,
  mlc_tick_if.sink                           tick,
  mlc_status_if.source                       status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mlc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [mlc_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output logic [mlc_pkg::CFG_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import mlc_pkg::*;

  mlc_cfg_t    cfg;
  mlc_tick_t   tick_q;
  logic        tick_valid;
  logic        advance;
  mlc_result_t result;
  mlc_result_t status_q;
  logic        status_valid;

  assign advance    = tick_valid && (!status_valid || status.ready);
  assign tick.ready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick.ready) begin
      tick_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      tick_q.request       <= tick.request;
      tick_q.unlock_switch <= tick.unlock_switch;
      tick_q.lock_switch   <= tick.lock_switch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (status.ready) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_q <= result;
    end
  end

  mlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlc_step u_step (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (tick_q),
    .cfg     (cfg),
    .result  (result)
  );

  assign status.valid        = status_valid;
  assign status.bridge_in1   = status_q.bridge_in1;
  assign status.bridge_in2   = status_q.bridge_in2;
  assign status.driver_awake = status_q.driver_awake;
  assign status.motor_power  = status_q.motor_power;
  assign status.position     = status_q.position;
  assign status.action       = status_q.action;
  assign status.lock_fails   = status_q.lock_fails;
  assign status.unlock_fails = status_q.unlock_fails;
  assign status.blocked      = status_q.blocked;
  assign status.timed_out    = status_q.timed_out;

endmodule

// ===== sim/lock_motor_checker.sv =====
// Status checker for the motor lock controller: follows the APB writes and the tick
// transfers, predicts each status item and compares it with the one the block sends.
// Depends on mlc_pkg, mlc_tick_if and mlc_status_if.
module lock_motor_checker (
  input  logic                               clk,
  input  logic                               rst,
  mlc_tick_if                                tick,
  mlc_status_if                              status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic                               pready,
  input  logic [mlc_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [mlc_pkg::CFG_DATA_WIDTH-1:0] pwdata,
  output int                                 errors,
  output int                                 pending
);
  import mlc_pkg::*;

  logic [TIMER_WIDTH-1:0]      protect_cfg, settle_cfg, sleep_cfg, autolock_cfg;
  logic [FAIL_COUNT_WIDTH-1:0] thresh_cfg;

  logic [1:0]                  run_act, tmr_kind, last_sw, pos;
  logic [TIMER_WIDTH-1:0]      tmr_left, slp_left;
  logic                        slp_on, seen_first;
  logic [FAIL_COUNT_WIDTH-1:0] lock_fail_cnt, unlock_fail_cnt;
  logic                        in1, in2, awake, power;
  bit                          tmr_fresh, slp_fresh, tmo;

  mlc_result_t want_status_q[$];

  function automatic logic [TIMER_WIDTH-1:0] nonzero(logic [TIMER_WIDTH-1:0] v);
    return (v == '0) ? TIMER_WIDTH'(1) : v;
  endfunction

  function automatic bit over_threshold();
    return (lock_fail_cnt > thresh_cfg) || (unlock_fail_cnt > thresh_cfg);
  endfunction

  function automatic void reset_model();
    protect_cfg     = 16'd1000;
    settle_cfg      = 16'd0;
    sleep_cfg       = 16'd200;
    autolock_cfg    = 16'd2000;
    thresh_cfg      = 12'd10;
    run_act         = ACT_IDLE;
    tmr_kind        = KIND_OFF;
    tmr_left        = '0;
    slp_left        = '0;
    slp_on          = 1'b0;
    lock_fail_cnt   = '0;
    unlock_fail_cnt = '0;
    last_sw         = 2'b00;
    in1             = 1'b1;
    in2             = 1'b1;
    awake           = 1'b0;
    power           = 1'b0;
    seen_first      = 1'b0;
  endfunction

  function automatic void brake();
    in1      = 1'b1;
    in2      = 1'b1;
    slp_left = nonzero((pos == POS_LOCKED) ? sleep_cfg : autolock_cfg);
    slp_on   = 1'b1;
    slp_fresh = 1'b1;
    run_act  = ACT_IDLE;
  endfunction

  function automatic void start_run(bit to_lock);
    if (to_lock ? (pos == POS_LOCKED) : (pos == POS_UNLOCKED)) return;
    if (run_act != ACT_IDLE) return;
    if (over_threshold()) return;
    tmr_kind  = KIND_PROTECT;
    tmr_left  = nonzero(protect_cfg);
    tmr_fresh = 1'b1;
    slp_on    = 1'b0;
    slp_left  = '0;
    run_act   = to_lock ? ACT_LOCK : ACT_UNLOCK;
    power     = 1'b1;
    awake     = 1'b1;
    in1       = !to_lock;
    in2       = to_lock;
  endfunction

  function automatic void settle_check();
    logic [1:0] act;
    bit failed;
    act = run_act;
    if (pos == POS_BETWEEN) return;
    tmr_kind = KIND_OFF;
    tmr_left = '0;
    brake();
    failed = (act == ACT_LOCK && pos != POS_LOCKED) ||
             (act == ACT_UNLOCK && pos != POS_UNLOCKED);
    if (!failed) begin
      lock_fail_cnt   = '0;
      unlock_fail_cnt = '0;
    end
  endfunction

  function automatic void protect_expired();
    tmr_kind = KIND_OFF;
    tmr_left = '0;
    if (run_act == ACT_LOCK) lock_fail_cnt = lock_fail_cnt + 1'b1;
    else if (run_act == ACT_UNLOCK) unlock_fail_cnt = unlock_fail_cnt + 1'b1;
    tmo = 1'b1;
    brake();
  endfunction

  function automatic mlc_result_t predict_status(logic [1:0] req, logic usw, logic lsw);
    mlc_result_t r;
    logic [1:0] sw;
    sw = {usw, lsw};
    if (usw && lsw) pos = POS_CONFLICT;
    else if (usw) pos = POS_UNLOCKED;
    else if (lsw) pos = POS_LOCKED;
    else pos = POS_BETWEEN;
    tmr_fresh = 1'b0;
    slp_fresh = 1'b0;
    tmo       = 1'b0;

    if (!seen_first) begin
      seen_first = 1'b1;
      last_sw    = sw;
      if (pos != POS_LOCKED) start_run(1'b1);
    end

    if (sw != last_sw) begin
      last_sw = sw;
      if (run_act != ACT_IDLE) begin
        if (settle_cfg == '0) begin
          settle_check();
        end else begin
          tmr_kind  = KIND_SETTLE;
          tmr_left  = settle_cfg;
          tmr_fresh = 1'b1;
        end
      end
    end

    if (tmr_kind != KIND_OFF && !tmr_fresh) begin
      tmr_left = tmr_left - 1'b1;
      if (tmr_left == '0) begin
        if (tmr_kind == KIND_PROTECT) begin
          protect_expired();
        end else begin
          tmr_kind = KIND_OFF;
          settle_check();
        end
      end
    end

    if (slp_on && !slp_fresh) begin
      slp_left = slp_left - 1'b1;
      if (slp_left == '0) begin
        slp_on = 1'b0;
        if (run_act == ACT_IDLE) begin
          if (pos == POS_LOCKED) begin
            awake = 1'b0;
            power = 1'b0;
          end else begin
            start_run(1'b1);
          end
        end else begin
          slp_left = nonzero(sleep_cfg);
          slp_on   = 1'b1;
        end
      end
    end

    if (req == REQ_LOCK) start_run(1'b1);
    else if (req == REQ_UNLOCK) start_run(1'b0);

    r.bridge_in1   = in1;
    r.bridge_in2   = in2;
    r.driver_awake = awake;
    r.motor_power  = power;
    r.position     = pos;
    r.action       = run_act;
    r.lock_fails   = lock_fail_cnt;
    r.unlock_fails = unlock_fail_cnt;
    r.blocked      = over_threshold();
    r.timed_out    = tmo;
    return r;
  endfunction

  task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    mlc_result_t want, got;
    if (rst) begin
      reset_model();
      want_status_q.delete();
      errors  = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_PROTECT:   protect_cfg  = pwdata[15:0];
          REG_SETTLE:    settle_cfg   = pwdata[15:0];
          REG_SLEEP:     sleep_cfg    = pwdata[15:0];
          REG_AUTO_LOCK: autolock_cfg = pwdata[15:0];
          REG_FAIL_THR:  thresh_cfg   = pwdata[11:0];
          default: ;
        endcase
      end

      if (status.valid && status.ready) begin
        got = '{status.bridge_in1, status.bridge_in2, status.driver_awake,
                status.motor_power, status.position, status.action, status.lock_fails,
                status.unlock_fails, status.blocked, status.timed_out};
        if (want_status_q.size() == 0) begin
          errors++;
          $display("%0t: status transfer expected none, got %h", $time, got);
        end else begin
          want = want_status_q.pop_front();
          check_field("bridge_in1", want.bridge_in1, got.bridge_in1);
          check_field("bridge_in2", want.bridge_in2, got.bridge_in2);
          check_field("driver_awake", want.driver_awake, got.driver_awake);
          check_field("motor_power", want.motor_power, got.motor_power);
          check_field("position", want.position, got.position);
          check_field("action", want.action, got.action);
          check_field("lock_fails", want.lock_fails, got.lock_fails);
          check_field("unlock_fails", want.unlock_fails, got.unlock_fails);
          check_field("blocked", want.blocked, got.blocked);
          check_field("timed_out", want.timed_out, got.timed_out);
        end
      end

      if (tick.valid && tick.ready)
        want_status_q.push_back(predict_status(tick.request, tick.unlock_switch,
                                               tick.lock_switch));

      pending <= want_status_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Top of the motor lock controller testbench: clock, reset, APB setup, tick stimulus
// and status back-pressure; verdict from the failure count of lock_motor_checker.
// Depends on mlc_pkg, mlc_tick_if, mlc_status_if, lock_motor_checker and the core.
module tb;
  import mlc_pkg::*;

  localparam int         STALL_LIMIT  = 2000;
  localparam int         PHASE_TICKS  = 100;
  localparam int         PHASES       = 10;
  localparam int         WRAP_TICKS   = 150;
  localparam logic [1:0] REQ_IDLE     = 2'd0;
  localparam logic [1:0] REQ_ILLEGAL  = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel, penable, pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [CFG_DATA_WIDTH-1:0] pwdata;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  int   mismatches, outstanding;
  int   ticks_sent = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  logic sw_unlock = 1'b0;
  logic sw_lock = 1'b0;

  mlc_tick_if   tick_ch ();
  mlc_status_if status_ch ();

  motor_lock_controller_core dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lock_motor_checker status_chk (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (mismatches),
    .pending (outstanding)
  );

  always #5 clk = ~clk;

  task automatic send_tick(logic [1:0] req, logic us, logic ls);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.request       <= req;
    tick_ch.unlock_switch <= us;
    tick_ch.lock_switch   <= ls;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int prot, int settle, int slp, int auto_lock, int thr);
    write_reg(REG_PROTECT,   {16'($urandom), 16'(prot)});
    write_reg(REG_SETTLE,    {16'($urandom), 16'(settle)});
    write_reg(REG_SLEEP,     {16'($urandom), 16'(slp)});
    write_reg(REG_AUTO_LOCK, {16'($urandom), 16'(auto_lock)});
    write_reg(REG_FAIL_THR,  {20'($urandom), 12'(thr)});
  endtask

  task automatic run_episode();
    int         kind;
    int         outcome;
    bit         to_lock;
    logic [1:0] req;
    kind = $urandom_range(0, 9);
    calm = ($urandom_range(0, 3) == 0);
    if (kind <= 5) begin
      to_lock = $urandom_range(0, 1);
      send_tick(to_lock ? REQ_LOCK : REQ_UNLOCK, sw_unlock, sw_lock);
      sw_unlock = 1'b0;
      sw_lock   = 1'b0;
      repeat ($urandom_range(0, 14)) begin
        req = ($urandom_range(0, 5) == 0) ? 2'($urandom) : REQ_IDLE;
        send_tick(req, sw_unlock, sw_lock);
      end
      outcome = $urandom_range(0, 9);
      if (outcome < 7) begin
        sw_unlock = !to_lock;
        sw_lock   = to_lock;
      end else if (outcome < 9) begin
        sw_unlock = 1'b1;
        sw_lock   = 1'b1;
      end
      repeat ($urandom_range(1, 15)) send_tick(REQ_IDLE, sw_unlock, sw_lock);
    end else if (kind <= 7) begin
      repeat ($urandom_range(1, 20)) send_tick(REQ_IDLE, sw_unlock, sw_lock);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        {sw_unlock, sw_lock} = 2'($urandom);
        send_tick(2'($urandom), sw_unlock, sw_lock);
      end
    end
  endtask

  initial begin
    int stall;
    status_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        status_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      status_ch.ready <= 1'b1;
      do @(posedge clk); while (!status_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready) ||
        psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_start;
    rst                   = 1'b1;
    tick_ch.valid         = 1'b0;
    tick_ch.request       = REQ_IDLE;
    tick_ch.unlock_switch = 1'b0;
    tick_ch.lock_switch   = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: relock on first tick, refusals, timeouts, conflict, blocking
    set_config(3, 0, 2, 4, 1);
    send_tick(REQ_IDLE,    1'b0, 1'b0);
    send_tick(REQ_UNLOCK,  1'b0, 1'b0);
    send_tick(REQ_IDLE,    1'b0, 1'b1);
    send_tick(REQ_LOCK,    1'b0, 1'b1);
    send_tick(REQ_IDLE,    1'b0, 1'b1);
    send_tick(REQ_UNLOCK,  1'b0, 1'b1);
    send_tick(REQ_IDLE,    1'b0, 1'b0);
    send_tick(REQ_ILLEGAL, 1'b0, 1'b0);
    send_tick(REQ_IDLE,    1'b0, 1'b0);
    send_tick(REQ_UNLOCK,  1'b0, 1'b0);
    send_tick(REQ_IDLE,    1'b1, 1'b1);
    send_tick(REQ_UNLOCK,  1'b1, 1'b1);
    repeat (3) send_tick(REQ_IDLE, 1'b1, 1'b1);
    send_tick(REQ_LOCK,    1'b1, 1'b1);
    send_tick(REQ_UNLOCK,  1'b1, 1'b0);
    repeat (4) send_tick(REQ_IDLE, 1'b1, 1'b0);

    // drive the lock fail count up with back-to-back timeouts, then clear it
    drain();
    set_config(1, 0, 1, 1, 4095);
    calm = 1'b1;
    repeat (WRAP_TICKS) send_tick(REQ_LOCK, 1'b0, 1'b0);
    send_tick(REQ_IDLE, 1'b0, 1'b1);
    sw_lock = 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: set_config(65535, 65535, 65535, 65535, 4095);
        1: set_config(0, 0, 0, 0, 0);
        2: set_config(1, 1, 1, 1, 0);
        default: begin
          if ($urandom_range(0, 5) == 0)
            set_config($urandom_range(1, 65535), $urandom_range(0, 65535),
                       $urandom_range(1, 65535), $urandom_range(1, 65535),
                       $urandom_range(0, 4095));
          else
            set_config($urandom_range(1, 12),
                       $urandom_range(0, 1) ? 0 : $urandom_range(1, 4),
                       $urandom_range(1, 8), $urandom_range(1, 12), $urandom_range(0, 4));
        end
      endcase
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < PHASE_TICKS) run_episode();
    end

    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mlc_pkg.sv
rtl/core/mlc_tick_if.sv
rtl/core/mlc_status_if.sv
rtl/core/mlc_cfg_regs.sv
rtl/core/mlc_step.sv
rtl/core/motor_lock_controller_core.sv
sim/lock_motor_checker.sv
sim/tb.sv
